>>> design/sort_and_byte_statistics_assert.svh
// assertion macros used by the checker file
`ifndef SORT_AND_BYTE_STATISTICS_ASSERT_SVH
`define SORT_AND_BYTE_STATISTICS_ASSERT_SVH
// same-cycle implication
`define SSBS_ASSERT_NOW(name, ck, rstn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define SSBS_ASSERT_NXT(name, ck, rstn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> design/ssbs_pkg.sv
// ----------------------------------------------------------------------------
// ssbs_pkg
// types and constants of the sort and byte statistics block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ssbs_pkg;
	localparam int SAMPLE_W   = 8;
	localparam int RANK_W     = 6;
	localparam int SUM_W      = 14;
	localparam int DIVISOR_W  = 7;
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last_sample;
	} in_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sorted_value;
		logic [RANK_W-1:0]   rank;
		logic [SAMPLE_W-1:0] mean_value;
		logic [SAMPLE_W-1:0] median_value;
		logic [SAMPLE_W-1:0] largest_value;
		logic [SAMPLE_W-1:0] smallest_value;
		logic                overflow_flag;
		logic                last_result;
	} result_t;

	// classified word carried from front to back
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
		logic                keep;
	} q_entry_t;

	typedef struct packed {
		logic                 go;
		logic [SUM_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [SAMPLE_W-1:0] quotient;
	} div_rsp_t;
endpackage

>>> design/sort_and_byte_statistics.sv
// ----------------------------------------------------------------------------
// sort_and_byte_statistics
// sorts a set of byte samples in descending order and reports statistics
// ----------------------------------------------------------------------------
// Usage: drive in_word and raise start; a word is taken at a clock edge where
// start is high and busy is low. A word with last_sample high ends the set.
// Up to MAX_COUNT samples are kept per set; further samples are dropped and
// reported through overflow_flag.
// Loading: a four-deep queue feeds an insertion sort chain that stores one
// sample per cycle while the back is loading and the queue holds a word.
// After the last word the mean is computed by a bit-serial divider, then one
// result per stored sample is shown on result for one cycle each, marked by
// result_valid, rank 0 first (largest). The final result has last_result set
// and carries mean, median, max, min and overflow_flag. Words of the next
// set are queued meanwhile until busy rises.
// Results cannot be held off by the receiver.
// Reset clears the counts, the queue and all control state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sort_and_byte_statistics import ssbs_pkg::*; #(
	parameter int MAX_COUNT = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_word_t in_word,
	output logic     busy,
	output logic     result_valid,
	output result_t  result
);
	logic     push;
	q_entry_t push_data;
	logic     full;
	logic     empty;
	logic     pop;
	q_entry_t pop_data;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// front: accept and classify
	ssbs_front #(.MAX_COUNT(MAX_COUNT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.in_word   (in_word),
		.full      (full),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	// queue
	ssbs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	// mean divider
	ssbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// back: sort and emit
	ssbs_back #(.MAX_COUNT(MAX_COUNT)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule

>>> design/ssbs_front.sv
// ----------------------------------------------------------------------------
// ssbs_front
// accepts sample words and tags each as stored or dropped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssbs_front import ssbs_pkg::*; #(
	parameter int MAX_COUNT = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_word_t in_word,
	input  logic     full,
	output logic     busy,
	output logic     push,
	output q_entry_t push_data
);
	localparam int CNT_W = $clog2(MAX_COUNT + 1);

	logic [CNT_W-1:0] count_q;
	logic             keep;

	// accept when the queue has room
	assign busy = full;
	assign push = start && !full;
	assign keep = (count_q < CNT_W'(MAX_COUNT));

	assign push_data.sample = in_word.sample;
	assign push_data.last   = in_word.last_sample;
	assign push_data.keep   = keep;

	// stored words in the current set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (in_word.last_sample) begin
				count_q <= '0;
			end else if (keep) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end
endmodule

>>> design/ssbs_fifo.sv
// ----------------------------------------------------------------------------
// ssbs_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssbs_fifo import ssbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	input  logic     pop,
	output q_entry_t pop_data,
	output logic     full,
	output logic     empty
);
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	q_entry_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   fill_q;

	assign full     = (fill_q == (PTR_W+1)'(FIFO_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if ((push && !full) && !(pop && !empty)) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (!(push && !full) && (pop && !empty)) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end
endmodule

>>> design/ssbs_div.sv
// ----------------------------------------------------------------------------
// ssbs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssbs_div import ssbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]     dq_q;
	logic [DIVISOR_W:0]   rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [STEP_W-1:0]    step_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIVISOR_W:0]   rem_sh;
	logic                 qbit;

	// shift in next dividend bit and trial subtract
	assign rem_sh = {rem_q[DIVISOR_W-1:0], dq_q[SUM_W-1]};
	assign qbit   = (rem_sh >= {1'b0, dsr_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (req.go) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			dq_q  <= {dq_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
		end
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

>>> design/ssbs_back.sv
// ----------------------------------------------------------------------------
// ssbs_back
// insertion sort chain, sum and count, then ordered emission with statistics
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssbs_back import ssbs_pkg::*; #(
	parameter int MAX_COUNT = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     empty,
	input  q_entry_t pop_data,
	output logic     pop,
	output div_req_t div_req,
	input  div_rsp_t div_rsp,
	output logic     result_valid,
	output result_t  result
);
	localparam int CNT_W = $clog2(MAX_COUNT + 1);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]          state_q;
	logic [SAMPLE_W-1:0] cell_q [MAX_COUNT];
	logic [SAMPLE_W-1:0] cell_ins [MAX_COUNT];
	logic [MAX_COUNT-1:0] ge;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    k_q;
	logic [SUM_W-1:0]    sum_q;
	logic                drop_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [CNT_W-1:0]    cnt_nx;
	logic [SUM_W-1:0]    sum_nx;
	logic                is_lo;
	logic                is_hi;
	logic                is_fin;
	logic [SAMPLE_W-1:0] lo_v;
	logic [SAMPLE_W-1:0] hi_v;
	logic [SAMPLE_W:0]   med_sum;
	result_t             res_d;

	assign pop = (state_q == ST_LOAD) && !empty;

	// count and sum after the popped word
	assign cnt_nx = pop_data.keep ? (cnt_q + CNT_W'(1)) : cnt_q;
	assign sum_nx = pop_data.keep ? SUM_W'(sum_q + SUM_W'(pop_data.sample)) : sum_q;

	assign div_req.go       = pop && pop_data.last;
	assign div_req.dividend = sum_nx;
	assign div_req.divisor  = DIVISOR_W'(cnt_nx);

	// insert position: cells holding a value not below the key stay put
	always_comb begin
		for (int i = 0; i < MAX_COUNT; i++) begin
			ge[i] = (CNT_W'(i) < cnt_q) && (cell_q[i] >= pop_data.sample);
		end
		for (int i = 0; i < MAX_COUNT; i++) begin
			if (ge[i]) begin
				cell_ins[i] = cell_q[i];
			end else if (i == 0) begin
				cell_ins[i] = pop_data.sample;
			end else if (ge[i-1]) begin
				cell_ins[i] = pop_data.sample;
			end else begin
				cell_ins[i] = cell_q[i-1];
			end
		end
	end

	// sort chain: insert while loading, shift toward cell 0 while emitting
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_COUNT; i++) begin
			if (pop && pop_data.keep) begin
				cell_q[i] <= cell_ins[i];
			end else if (state_q == ST_EMIT) begin
				if (i < MAX_COUNT - 1) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end
	end

	// median and extreme tracking during emission
	assign is_lo  = (k_q == ((cnt_q - CNT_W'(1)) >> 1));
	assign is_hi  = (k_q == (cnt_q >> 1));
	assign is_fin = (k_q == (cnt_q - CNT_W'(1)));
	assign lo_v   = is_lo ? cell_q[0] : lo_q;
	assign hi_v   = is_hi ? cell_q[0] : hi_q;
	assign med_sum = {1'b0, lo_v} + {1'b0, hi_v};

	always_comb begin
		res_d = '0;
		res_d.sorted_value = cell_q[0];
		res_d.rank         = RANK_W'(k_q);
		if (is_fin) begin
			res_d.mean_value     = mean_q;
			res_d.median_value   = med_sum[SAMPLE_W:1];
			res_d.largest_value  = (k_q == '0) ? cell_q[0] : max_q;
			res_d.smallest_value = cell_q[0];
			res_d.overflow_flag  = drop_q;
			res_d.last_result    = 1'b1;
		end
	end

	// result register and statistics capture
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			result <= res_d;
			if (is_lo) begin
				lo_q <= cell_q[0];
			end
			if (is_hi) begin
				hi_q <= cell_q[0];
			end
			if (k_q == '0) begin
				max_q <= cell_q[0];
			end
		end
		if (div_rsp.done) begin
			mean_q <= div_rsp.quotient;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			cnt_q        <= '0;
			sum_q        <= '0;
			drop_q       <= 1'b0;
			k_q          <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						cnt_q  <= cnt_nx;
						sum_q  <= sum_nx;
						drop_q <= drop_q | !pop_data.keep;
						if (pop_data.last) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					k_q <= '0;
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					result_valid <= 1'b1;
					k_q          <= k_q + CNT_W'(1);
					if (is_fin) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
						sum_q   <= '0;
						drop_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end
endmodule

>>> design/ssbs_checker.sv
// ----------------------------------------------------------------------------
// ssbs_checker
// port-level checks of the result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sort_and_byte_statistics_assert.svh"
module ssbs_checker import ssbs_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     result_valid,
	input result_t  result
);
	// a set is emitted in consecutive cycles
	`SSBS_ASSERT_NXT(a_burst, clk, arst_n, result_valid && !result.last_result, result_valid)
	// a gap without results follows every final result
	`SSBS_ASSERT_NXT(a_gap, clk, arst_n, result_valid && result.last_result, !result_valid)
	// statistics fields stay zero before the final result
	`SSBS_ASSERT_NOW(a_zero, clk, arst_n, result_valid && !result.last_result, result.mean_value == '0 && result.median_value == '0 && result.largest_value == '0 && result.smallest_value == '0 && !result.overflow_flag)
	// ranks count up and values do not rise within a set
	`SSBS_ASSERT_NOW(a_order, clk, arst_n, result_valid && $past(result_valid) && !$past(result.last_result), result.rank == $past(result.rank) + 6'd1 && result.sorted_value <= $past(result.sorted_value))
endmodule

bind sort_and_byte_statistics ssbs_checker u_ssbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result       (result)
);
